@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent; clocked by clk, reset by rst_n.
`define AAVR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent; clocked by clk, reset by rst_n.
`define AAVR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/aavr_pkg.sv @@
// Types, constants and helper functions of the axis-angle vector rotation block.
package aavr_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int PHASE_SHIFT = FRAC_BITS + 3;
    localparam int PM_W        = PHASE_SHIFT + 32;

    localparam int ROOT_BITS = 32;
    localparam int DIV_BITS  = 31;
    localparam int NUM_W     = 62;

    localparam logic [31:0] HALF_TURN_K = 32'd2734261102;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [63:0] ROUND_HALF  = 64'h0000_0000_2000_0000;

    localparam int HORNER_STEPS = 6;
    localparam int SIN_STEPS    = 5;

    localparam logic [7:0] COS_DIV [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [31:0] COS_RECIP [HORNER_STEPS] = '{
        32'd32537631, 32'd47721858, 32'd76695844,
        32'd143165576, 32'd357913941, 32'd2147483648
    };
    localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [31:0] SIN_RECIP [SIN_STEPS] = '{
        32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882
    };

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } result_t;

    typedef struct packed {
        item_t       item;
        logic [31:0] m;
    } tr_side_t;

    typedef struct packed {
        logic [29:0] t;
        logic [29:0] t2;
        logic [1:0]  k;
        logic        neg;
        logic [30:0] ps;
        logic [30:0] pc;
        logic [29:0] xs;
        logic [29:0] xc;
        logic [29:0] q0s;
        logic [29:0] q0c;
    } horner_t;

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] cs;
        logic [2:0]         neg;
        logic               mzero;
    } dv_side_t;

    function automatic logic [63:0] smul64(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p;
    endfunction

    // Add half an LSB and drop 30 fraction bits (floor).
    function automatic logic signed [33:0] round30(input logic [63:0] acc);
        logic [63:0] s;
        s = acc + ROUND_HALF;
        return s[63:30];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

@@ rtl/aavr_isqrt.sv @@
// Pipelined integer square root, one root bit per stage, with side payload.
module aavr_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_vld,
    input  logic [2*aavr_pkg::ROOT_BITS-1:0] x,
    input  aavr_pkg::item_t             in_side,
    output logic                        out_vld,
    output logic [aavr_pkg::ROOT_BITS-1:0] root,
    output aavr_pkg::item_t             out_side
);

    localparam int RB = aavr_pkg::ROOT_BITS;
    localparam int XW = 2 * RB;

    logic            vld_reg  [RB];
    logic [XW-1:0]   rem_reg  [RB];
    logic [RB-1:0]   root_reg [RB];
    aavr_pkg::item_t side_reg [RB];

    for (genvar i = 0; i < RB; i++) begin : g_stage
        localparam int B = RB - 1 - i;
        logic            vld_cur;
        logic [XW-1:0]   rem_cur;
        logic [RB-1:0]   root_cur;
        aavr_pkg::item_t side_cur;
        logic [XW-1:0]   trial;

        if (i == 0) begin : g_first
            assign vld_cur  = in_vld;
            assign rem_cur  = x;
            assign root_cur = '0;
            assign side_cur = in_side;
        end else begin : g_rest
            assign vld_cur  = vld_reg[i-1];
            assign rem_cur  = rem_reg[i-1];
            assign root_cur = root_reg[i-1];
            assign side_cur = side_reg[i-1];
        end

        // (r + 2^B)^2 - r^2
        assign trial = (XW'(root_cur) << (B + 1)) + (XW'(1) << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[i] <= side_cur;
                if (rem_cur >= trial)
                begin
                    rem_reg[i]  <= rem_cur - trial;
                    root_reg[i] <= root_cur | (RB'(1) << B);
                end
                else
                begin
                    rem_reg[i]  <= rem_cur;
                    root_reg[i] <= root_cur;
                end
            end
        end
    end

    assign out_vld  = vld_reg[RB-1];
    assign root     = root_reg[RB-1];
    assign out_side = side_reg[RB-1];

endmodule

@@ rtl/aavr_div.sv @@
// Pipelined three-lane restoring divider, one quotient bit per stage.
module aavr_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  logic                                   in_vld,
    input  logic [2:0][aavr_pkg::NUM_W-1:0]        num,
    input  logic [31:0]                            den,
    input  aavr_pkg::dv_side_t                     in_side,
    output logic                                   out_vld,
    output logic [2:0][aavr_pkg::DIV_BITS-1:0]     quo,
    output aavr_pkg::dv_side_t                     out_side
);

    localparam int DB = aavr_pkg::DIV_BITS;
    localparam int NW = aavr_pkg::NUM_W;

    logic                        vld_reg  [DB];
    logic [2:0][NW-1:0]          rem_reg  [DB];
    logic [2:0][DB-1:0]          quo_reg  [DB];
    logic [31:0]                 den_reg  [DB];
    aavr_pkg::dv_side_t          side_reg [DB];

    for (genvar i = 0; i < DB; i++) begin : g_stage
        localparam int B = DB - 1 - i;
        logic                vld_cur;
        logic [2:0][NW-1:0]  rem_cur;
        logic [2:0][DB-1:0]  quo_cur;
        logic [31:0]         den_cur;
        aavr_pkg::dv_side_t  side_cur;
        logic [NW:0]         sub;
        logic [2:0][NW-1:0]  rem_nxt;
        logic [2:0][DB-1:0]  quo_nxt;

        if (i == 0) begin : g_first
            assign vld_cur  = in_vld;
            assign rem_cur  = num;
            assign quo_cur  = '0;
            assign den_cur  = den;
            assign side_cur = in_side;
        end else begin : g_rest
            assign vld_cur  = vld_reg[i-1];
            assign rem_cur  = rem_reg[i-1];
            assign quo_cur  = quo_reg[i-1];
            assign den_cur  = den_reg[i-1];
            assign side_cur = side_reg[i-1];
        end

        assign sub = (NW + 1)'(den_cur) << B;

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                if ((NW + 1)'(rem_cur[l]) >= sub)
                begin
                    rem_nxt[l] = rem_cur[l] - sub[NW-1:0];
                    quo_nxt[l] = quo_cur[l] | (DB'(1) << B);
                end
                else
                begin
                    rem_nxt[l] = rem_cur[l];
                    quo_nxt[l] = quo_cur[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_nxt;
                quo_reg[i]  <= quo_nxt;
                den_reg[i]  <= den_cur;
                side_reg[i] <= side_cur;
            end
        end
    end

    assign out_vld  = vld_reg[DB-1];
    assign quo      = quo_reg[DB-1];
    assign out_side = side_reg[DB-1];

endmodule

@@ rtl/axis_angle_vector_rotation.sv @@
// Throughput: one item per cycle while item_stall is low; the 32-stage square root, the six
// Horner steps (three stages each) and the 31-stage divider are fully pipelined.
// A two-entry output queue absorbs results while result_stall is high.
// Reset (rst_n low, asynchronous) clears all valid bits and empties the queue.
module axis_angle_vector_rotation (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  aavr_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output aavr_pkg::result_t result
);

    localparam int HS = aavr_pkg::HORNER_STEPS;
    localparam int HN = 3 * HS;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Global advance: hold the whole pipe only when the last stage has a
    // transaction and the output queue has no room for it.
    logic adv;

    //------------------------------------------------------------------
    // Squares of the rotation vector, then their sum
    //------------------------------------------------------------------
    logic            s1_vld_reg;
    aavr_pkg::item_t s1_item_reg;
    logic [63:0]     s1_sq_reg [3];
    logic            s2_vld_reg;
    aavr_pkg::item_t s2_item_reg;
    logic [63:0]     s2_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= item_valid;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg  <= item;
            s1_sq_reg[0] <= aavr_pkg::smul64(item.rot_x, item.rot_x);
            s1_sq_reg[1] <= aavr_pkg::smul64(item.rot_y, item.rot_y);
            s1_sq_reg[2] <= aavr_pkg::smul64(item.rot_z, item.rot_z);
            s2_item_reg  <= s1_item_reg;
            s2_sum_reg   <= s1_sq_reg[0] + s1_sq_reg[1] + s1_sq_reg[2];
        end
    end

    //------------------------------------------------------------------
    // Angle magnitude M = floor(sqrt(sum))
    //------------------------------------------------------------------
    logic            sq_vld;
    logic [31:0]     sq_root;
    aavr_pkg::item_t sq_item;

    aavr_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (s2_vld_reg),
        .x        (s2_sum_reg),
        .in_side  (s2_item_reg),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .out_side (sq_item)
    );

    //------------------------------------------------------------------
    // Half-angle phase, quadrant reduction, residual angle t and t^2
    //------------------------------------------------------------------
    logic                      s3_vld_reg;
    aavr_pkg::tr_side_t        s3_side_reg;
    logic [aavr_pkg::PM_W-1:0] s3_pm_reg;
    logic                      s4_vld_reg;
    aavr_pkg::tr_side_t        s4_side_reg;
    logic [29:0]               s4_mag_reg;
    logic [1:0]                s4_k_reg;
    logic                      s4_neg_reg;
    logic                      s5_vld_reg;
    aavr_pkg::tr_side_t        s5_side_reg;
    logic [29:0]               s5_t_reg;
    logic [1:0]                s5_k_reg;
    logic                      s5_neg_reg;

    logic [31:0] s4_phase;
    logic [31:0] s4_rnd;
    logic [1:0]  s4_k;
    logic [31:0] s4_d;
    logic [31:0] s4_dabs;
    logic [61:0] s5_prod;
    logic [59:0] s6_prod;

    assign s4_phase = s3_pm_reg[aavr_pkg::PHASE_SHIFT +: 32];
    assign s4_rnd   = s4_phase + 32'h2000_0000;
    assign s4_k     = s4_rnd[31:30];
    assign s4_d     = s4_phase - {s4_k, 30'd0};
    assign s4_dabs  = s4_d[31] ? (~s4_d + 32'd1) : s4_d;
    assign s5_prod  = 62'(s4_mag_reg) * 62'(aavr_pkg::PI_Q30);
    assign s6_prod  = 60'(s5_t_reg) * 60'(s5_t_reg);

    // Horner pipe: index 0 holds t, t^2 and the starting polynomials.
    logic               hvld_reg  [HN+1];
    aavr_pkg::tr_side_t hside_reg [HN+1];
    aavr_pkg::horner_t  hn_reg    [HN+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            hvld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            s3_vld_reg  <= sq_vld;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            hvld_reg[0] <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg.item <= sq_item;
            s3_side_reg.m    <= sq_root;
            s3_pm_reg        <= aavr_pkg::PM_W'(sq_root) * aavr_pkg::PM_W'(aavr_pkg::HALF_TURN_K);

            s4_side_reg <= s3_side_reg;
            s4_mag_reg  <= s4_dabs[29:0];
            s4_k_reg    <= s4_k;
            s4_neg_reg  <= s4_d[31];

            s5_side_reg <= s4_side_reg;
            s5_t_reg    <= s5_prod[60:31];
            s5_k_reg    <= s4_k_reg;
            s5_neg_reg  <= s4_neg_reg;

            hside_reg[0]  <= s5_side_reg;
            hn_reg[0].t   <= s5_t_reg;
            hn_reg[0].t2  <= s6_prod[59:30];
            hn_reg[0].k   <= s5_k_reg;
            hn_reg[0].neg <= s5_neg_reg;
            hn_reg[0].ps  <= aavr_pkg::Q30_ONE;
            hn_reg[0].pc  <= aavr_pkg::Q30_ONE;
            hn_reg[0].xs  <= '0;
            hn_reg[0].xc  <= '0;
            hn_reg[0].q0s <= '0;
            hn_reg[0].q0c <= '0;
        end
    end

    //------------------------------------------------------------------
    // Horner steps p = 1 - ((t2*p) >> 30) / (n*(n+1)), three stages each:
    // multiply, reciprocal multiply, remainder correction
    //------------------------------------------------------------------
    for (genvar j = 0; j < HS; j++) begin : g_step
        localparam int IA = 3 * j;
        aavr_pkg::horner_t na;
        aavr_pkg::horner_t nb;
        aavr_pkg::horner_t nc;
        logic [60:0] pa_c;
        logic [60:0] pa_s;
        logic [61:0] pb_c;
        logic [61:0] pb_s;
        logic [37:0] rc;
        logic [37:0] rs;

        assign pa_c = 61'(hn_reg[IA].t2) * 61'(hn_reg[IA].pc);
        assign pa_s = 61'(hn_reg[IA].t2) * 61'(hn_reg[IA].ps);
        assign pb_c = 62'(hn_reg[IA+1].xc) * 62'(aavr_pkg::COS_RECIP[j]);
        assign rc   = 38'(hn_reg[IA+2].xc)
                    - 38'(hn_reg[IA+2].q0c) * 38'(aavr_pkg::COS_DIV[j]);

        if (j < aavr_pkg::SIN_STEPS) begin : g_sin
            assign pb_s = 62'(hn_reg[IA+1].xs) * 62'(aavr_pkg::SIN_RECIP[j]);
            assign rs   = 38'(hn_reg[IA+2].xs)
                        - 38'(hn_reg[IA+2].q0s) * 38'(aavr_pkg::SIN_DIV[j]);
        end else begin : g_nosin
            assign pb_s = '0;
            assign rs   = '0;
        end

        always_comb
        begin
            na    = hn_reg[IA];
            na.xc = pa_c[59:30];
            na.xs = pa_s[59:30];

            nb     = hn_reg[IA+1];
            nb.q0c = pb_c[61:32];
            nb.q0s = pb_s[61:32];

            nc    = hn_reg[IA+2];
            nc.pc = aavr_pkg::Q30_ONE - 31'(hn_reg[IA+2].q0c)
                  - ((rc >= 38'(aavr_pkg::COS_DIV[j])) ? 31'd1 : 31'd0);
            if (j < aavr_pkg::SIN_STEPS)
            begin
                nc.ps = aavr_pkg::Q30_ONE - 31'(hn_reg[IA+2].q0s)
                      - ((rs >= 38'(aavr_pkg::SIN_DIV[j % aavr_pkg::SIN_STEPS]))
                         ? 31'd1 : 31'd0);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hvld_reg[IA+1] <= 1'b0;
                hvld_reg[IA+2] <= 1'b0;
                hvld_reg[IA+3] <= 1'b0;
            end
            else if (adv)
            begin
                hvld_reg[IA+1] <= hvld_reg[IA];
                hvld_reg[IA+2] <= hvld_reg[IA+1];
                hvld_reg[IA+3] <= hvld_reg[IA+2];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                hn_reg[IA+1]    <= na;
                hn_reg[IA+2]    <= nb;
                hn_reg[IA+3]    <= nc;
                hside_reg[IA+1] <= hside_reg[IA];
                hside_reg[IA+2] <= hside_reg[IA+1];
                hside_reg[IA+3] <= hside_reg[IA+2];
            end
        end
    end

    //------------------------------------------------------------------
    // sin = t * ps, sign and quadrant, then rot_i * sin
    //------------------------------------------------------------------
    logic               fn_vld_reg;
    aavr_pkg::tr_side_t fn_side_reg;
    logic [30:0]        fn_s_reg;
    logic [30:0]        fn_c_reg;
    logic [1:0]         fn_k_reg;
    logic               fn_neg_reg;
    logic               qd_vld_reg;
    aavr_pkg::tr_side_t qd_side_reg;
    logic signed [31:0] qd_sn_reg;
    logic signed [31:0] qd_cs_reg;

    logic [60:0]        fn_prod;
    logic signed [31:0] qd_s;
    logic signed [31:0] qd_c;
    logic signed [31:0] qd_sn;
    logic signed [31:0] qd_cs;

    assign fn_prod = 61'(hn_reg[HN].t) * 61'(hn_reg[HN].ps);
    assign qd_c    = 32'(fn_c_reg);
    assign qd_s    = fn_neg_reg ? -32'(fn_s_reg) : 32'(fn_s_reg);

    always_comb
    begin
        unique case (fn_k_reg)
            QUAD_0:
            begin
                qd_sn = qd_s;
                qd_cs = qd_c;
            end
            QUAD_1:
            begin
                qd_sn = qd_c;
                qd_cs = -qd_s;
            end
            QUAD_2:
            begin
                qd_sn = -qd_s;
                qd_cs = -qd_c;
            end
            QUAD_3:
            begin
                qd_sn = -qd_c;
                qd_cs = qd_s;
            end
        endcase
    end

    // Dividend magnitudes for q_i = rot_i * sin / M, truncated toward zero.
    logic                       dm_vld_reg;
    logic [2:0][aavr_pkg::NUM_W-1:0] dm_num_reg;
    logic [31:0]                dm_den_reg;
    aavr_pkg::dv_side_t         dm_side_reg;

    logic [63:0]                dm_prod [3];
    logic [2:0][aavr_pkg::NUM_W-1:0] dm_num;
    logic [2:0]                 dm_neg;

    assign dm_prod[0] = aavr_pkg::smul64(qd_side_reg.item.rot_x, qd_sn_reg);
    assign dm_prod[1] = aavr_pkg::smul64(qd_side_reg.item.rot_y, qd_sn_reg);
    assign dm_prod[2] = aavr_pkg::smul64(qd_side_reg.item.rot_z, qd_sn_reg);

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            dm_neg[l] = dm_prod[l][63];
            dm_num[l] = dm_prod[l][63] ? aavr_pkg::NUM_W'(~dm_prod[l] + 64'd1)
                                       : aavr_pkg::NUM_W'(dm_prod[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fn_vld_reg <= 1'b0;
            qd_vld_reg <= 1'b0;
            dm_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            fn_vld_reg <= hvld_reg[HN];
            qd_vld_reg <= fn_vld_reg;
            dm_vld_reg <= qd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fn_side_reg <= hside_reg[HN];
            fn_s_reg    <= fn_prod[60:30];
            fn_c_reg    <= hn_reg[HN].pc;
            fn_k_reg    <= hn_reg[HN].k;
            fn_neg_reg  <= hn_reg[HN].neg;

            qd_side_reg <= fn_side_reg;
            qd_sn_reg   <= qd_sn;
            qd_cs_reg   <= qd_cs;

            dm_num_reg        <= dm_num;
            dm_den_reg        <= qd_side_reg.m;
            dm_side_reg.vec_x <= qd_side_reg.item.vec_x;
            dm_side_reg.vec_y <= qd_side_reg.item.vec_y;
            dm_side_reg.vec_z <= qd_side_reg.item.vec_z;
            dm_side_reg.cs    <= qd_cs_reg;
            dm_side_reg.neg   <= dm_neg;
            dm_side_reg.mzero <= (qd_side_reg.m == 32'd0);
        end
    end

    logic                               dv_vld;
    logic [2:0][aavr_pkg::DIV_BITS-1:0] dv_quo;
    aavr_pkg::dv_side_t                 dv_side;

    aavr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (dm_vld_reg),
        .num      (dm_num_reg),
        .den      (dm_den_reg),
        .in_side  (dm_side_reg),
        .out_vld  (dv_vld),
        .quo      (dv_quo),
        .out_side (dv_side)
    );

    //------------------------------------------------------------------
    // Quaternion, then r = v * conj(q) and o = q * r
    //------------------------------------------------------------------
    logic               qt_vld_reg;
    logic signed [31:0] qt_q_reg [4];
    logic signed [31:0] qt_v_reg [3];
    logic               h1m_vld_reg;
    logic [63:0]        h1m_p_reg [12];
    logic signed [31:0] h1m_q_reg [4];
    logic               h1s_vld_reg;
    logic signed [33:0] h1s_r_reg [4];
    logic signed [31:0] h1s_q_reg [4];
    logic               h2m_vld_reg;
    logic [63:0]        h2m_p_reg [12];
    logic               h2s_vld_reg;
    aavr_pkg::result_t  h2s_res_reg;

    logic signed [31:0] qt_q [3];
    aavr_pkg::result_t  h2s_res;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (dv_side.mzero)
            begin
                qt_q[l] = '0;
            end
            else if (dv_side.neg[l])
            begin
                qt_q[l] = -32'(dv_quo[l]);
            end
            else
            begin
                qt_q[l] = 32'(dv_quo[l]);
            end
        end
    end

    assign h2s_res.out_x = aavr_pkg::sat32(aavr_pkg::round30(
        h2m_p_reg[0] + h2m_p_reg[1] + h2m_p_reg[2] - h2m_p_reg[3]));
    assign h2s_res.out_y = aavr_pkg::sat32(aavr_pkg::round30(
        h2m_p_reg[4] - h2m_p_reg[5] + h2m_p_reg[6] + h2m_p_reg[7]));
    assign h2s_res.out_z = aavr_pkg::sat32(aavr_pkg::round30(
        h2m_p_reg[8] + h2m_p_reg[9] - h2m_p_reg[10] + h2m_p_reg[11]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qt_vld_reg  <= 1'b0;
            h1m_vld_reg <= 1'b0;
            h1s_vld_reg <= 1'b0;
            h2m_vld_reg <= 1'b0;
            h2s_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            qt_vld_reg  <= dv_vld;
            h1m_vld_reg <= qt_vld_reg;
            h1s_vld_reg <= h1m_vld_reg;
            h2m_vld_reg <= h1s_vld_reg;
            h2s_vld_reg <= h2m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qt_q_reg[0] <= dv_side.cs;
            qt_q_reg[1] <= qt_q[0];
            qt_q_reg[2] <= qt_q[1];
            qt_q_reg[3] <= qt_q[2];
            qt_v_reg[0] <= dv_side.vec_x;
            qt_v_reg[1] <= dv_side.vec_y;
            qt_v_reg[2] <= dv_side.vec_z;

            // v * conj(q), v has zero scalar part
            h1m_p_reg[0]  <= aavr_pkg::smul64(qt_v_reg[0], qt_q_reg[1]);
            h1m_p_reg[1]  <= aavr_pkg::smul64(qt_v_reg[1], qt_q_reg[2]);
            h1m_p_reg[2]  <= aavr_pkg::smul64(qt_v_reg[2], qt_q_reg[3]);
            h1m_p_reg[3]  <= aavr_pkg::smul64(qt_v_reg[0], qt_q_reg[0]);
            h1m_p_reg[4]  <= aavr_pkg::smul64(qt_v_reg[1], qt_q_reg[3]);
            h1m_p_reg[5]  <= aavr_pkg::smul64(qt_v_reg[2], qt_q_reg[2]);
            h1m_p_reg[6]  <= aavr_pkg::smul64(qt_v_reg[0], qt_q_reg[3]);
            h1m_p_reg[7]  <= aavr_pkg::smul64(qt_v_reg[1], qt_q_reg[0]);
            h1m_p_reg[8]  <= aavr_pkg::smul64(qt_v_reg[2], qt_q_reg[1]);
            h1m_p_reg[9]  <= aavr_pkg::smul64(qt_v_reg[0], qt_q_reg[2]);
            h1m_p_reg[10] <= aavr_pkg::smul64(qt_v_reg[1], qt_q_reg[1]);
            h1m_p_reg[11] <= aavr_pkg::smul64(qt_v_reg[2], qt_q_reg[0]);
            h1m_q_reg     <= qt_q_reg;

            h1s_r_reg[0] <= aavr_pkg::round30(h1m_p_reg[0] + h1m_p_reg[1] + h1m_p_reg[2]);
            h1s_r_reg[1] <= aavr_pkg::round30(h1m_p_reg[3] - h1m_p_reg[4] + h1m_p_reg[5]);
            h1s_r_reg[2] <= aavr_pkg::round30(h1m_p_reg[6] + h1m_p_reg[7] - h1m_p_reg[8]);
            h1s_r_reg[3] <= aavr_pkg::round30(h1m_p_reg[10] + h1m_p_reg[11] - h1m_p_reg[9]);
            h1s_q_reg    <= h1m_q_reg;

            // q * r
            h2m_p_reg[0]  <= aavr_pkg::smul64(h1s_q_reg[0], h1s_r_reg[1]);
            h2m_p_reg[1]  <= aavr_pkg::smul64(h1s_q_reg[1], h1s_r_reg[0]);
            h2m_p_reg[2]  <= aavr_pkg::smul64(h1s_q_reg[2], h1s_r_reg[3]);
            h2m_p_reg[3]  <= aavr_pkg::smul64(h1s_q_reg[3], h1s_r_reg[2]);
            h2m_p_reg[4]  <= aavr_pkg::smul64(h1s_q_reg[0], h1s_r_reg[2]);
            h2m_p_reg[5]  <= aavr_pkg::smul64(h1s_q_reg[1], h1s_r_reg[3]);
            h2m_p_reg[6]  <= aavr_pkg::smul64(h1s_q_reg[2], h1s_r_reg[0]);
            h2m_p_reg[7]  <= aavr_pkg::smul64(h1s_q_reg[3], h1s_r_reg[1]);
            h2m_p_reg[8]  <= aavr_pkg::smul64(h1s_q_reg[0], h1s_r_reg[3]);
            h2m_p_reg[9]  <= aavr_pkg::smul64(h1s_q_reg[1], h1s_r_reg[2]);
            h2m_p_reg[10] <= aavr_pkg::smul64(h1s_q_reg[2], h1s_r_reg[1]);
            h2m_p_reg[11] <= aavr_pkg::smul64(h1s_q_reg[3], h1s_r_reg[0]);

            h2s_res_reg <= h2s_res;
        end
    end

    //------------------------------------------------------------------
    // Two-entry output queue
    //------------------------------------------------------------------
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    aavr_pkg::result_t buf_reg [2];
    logic              push;
    logic              pop;

    assign adv          = !(h2s_vld_reg && (cnt_reg == 2'd2));
    assign item_stall   = !adv;
    assign push         = adv && h2s_vld_reg;
    assign result_valid = (cnt_reg != 2'd0);
    assign pop          = result_valid && !result_stall;
    assign result       = buf_reg[0];
    assign cnt_next     = cnt_reg + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && push)
        begin
            buf_reg[0] <= h2s_res_reg;
        end
        else if (pop)
        begin
            buf_reg[0] <= buf_reg[1];
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                buf_reg[0] <= h2s_res_reg;
            end
            else
            begin
                buf_reg[1] <= h2s_res_reg;
            end
        end
    end

endmodule

@@ rtl/aavr_checker.sv @@
// Port-level assertions for the axis-angle vector rotation block, with its bind.
`include "assert_macros.svh"

module aavr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input aavr_pkg::result_t result
);

    // A stalled result transaction stays offered and unchanged.
    `AAVR_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid, "result dropped")
    `AAVR_ASSERT_NEXT(a_res_stable, result_valid && result_stall, $stable(result), "result moved")

    // Input stalls only when the output queue holds results.
    `AAVR_ASSERT_SAME(a_stall_cause, item_stall, result_valid, "stall with empty output")

    // Draining a full queue frees the input in the next cycle.
    `AAVR_ASSERT_NEXT(a_stall_release, item_stall && !result_stall, !item_stall, "stall held")

endmodule

bind axis_angle_vector_rotation aavr_checker u_aavr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
